/* hw/rtl/ush_pkg.sv */
// Package for the unordered handle set: sizes, request and event codes,
// and the sequencer state type. No dependencies.
package ush_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int MAX_RUN   = 16;
  localparam int RUN_W     = $clog2(MAX_RUN);
  localparam int HANDLE_W  = 32;
  localparam int REQ_W     = 3;
  localparam int EIDX_W    = 4;
  localparam int KIND_W    = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TAKE     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd5;

  // Event codes
  localparam logic [KIND_W-1:0] EV_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] EV_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] EV_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_RD_ITEM,
    ST_RD_LAST,
    ST_WRITE,
    ST_RESULT
  } seq_state_t;

endpackage

/* hw/rtl/ush_req_if.sv */
// Request channel of the unordered handle set: valid/ready plus payload.
// Depends on ush_pkg for field widths.
interface ush_req_if;
  logic                          valid;
  logic                          ready;
  logic [ush_pkg::REQ_W-1:0]     req_type;
  logic [ush_pkg::HANDLE_W-1:0]  item_value;
  logic [ush_pkg::EIDX_W-1:0]    entry_index;

  modport source (output valid, req_type, item_value, entry_index, input ready);
  modport sink   (input valid, req_type, item_value, entry_index, output ready);
endinterface

/* hw/rtl/ush_res_if.sv */
// Result channel of the unordered handle set: valid/ready plus payload.
// Depends on ush_pkg for field widths.
interface ush_res_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          found;
  logic [ush_pkg::HANDLE_W-1:0]  item_out;
  logic [ush_pkg::KIND_W-1:0]    event_kind;
  logic [ush_pkg::EIDX_W-1:0]    event_index;
  logic                          last_of_run;

  modport source (output valid, status, found, item_out, event_kind, event_index,
                  last_of_run, input ready);
  modport sink   (input valid, status, found, item_out, event_kind, event_index,
                  last_of_run, output ready);
endinterface

/* hw/rtl/unordered_handle_set.sv */
// Top level of the unordered handle set: handle store, count, take cursor
// and the sequencer that drives one shared store port and compare unit.
// Depends on ush_pkg, ush_req_if and ush_res_if.
//
// Usage:
//   req (sink) takes one request beat at a time: append, delete at index,
//   remove by value, contains, take, clear. res (source) returns result
//   beats; last_of_run marks the final beat of a request. Only clear gives
//   more than one beat (one remove event per entry, up to 16).
// Steps:
//   append, failed requests, empty clear: straight to the result beat.
//   delete at index: read the victim, read the last entry, write it into
//   the hole. remove / contains: search first (one store read per cycle
//   through the single read port). take: reduce the cursor modulo the count
//   by repeated compare-subtract first. clear: the delete steps per entry.
// A new request is taken only when the sequencer is idle; the result
// register lets it take one while the previous result beat still waits.
// A stalled receiver holds the result beat and the sequencer waits on it.
// Reset empties the set and zeroes the cursor; the store itself is not
// cleared since no entry at or above the count is ever read.
module unordered_handle_set (
  input  logic      clk,
  input  logic      rst,
  ush_req_if.sink   req,
  ush_res_if.source res
);
  import ush_pkg::*;

  // Handle store
  logic [HANDLE_W-1:0] mem [CAPACITY];
  logic [HANDLE_W-1:0] rdata;
  logic [IDX_W-1:0]    ra;
  logic                we;
  logic [IDX_W-1:0]    wa;
  logic [HANDLE_W-1:0] wd;

  // Sequencer state
  seq_state_t          state, state_next;
  logic [REQ_W-1:0]    op, op_next;
  logic [HANDLE_W-1:0] val, val_next;
  logic [IDX_W-1:0]    pos, pos_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    cursor, cursor_next;
  logic [CNT_W-1:0]    scan, scan_next;
  logic                pend, pend_next;
  logic [IDX_W-1:0]    cmp_idx, cmp_idx_next;
  logic [RUN_W-1:0]    run, run_next;

  // Pending result fields
  logic                r_status, r_status_next;
  logic                r_found, r_found_next;
  logic [HANDLE_W-1:0] r_item, r_item_next;
  logic [KIND_W-1:0]   r_kind, r_kind_next;
  logic [EIDX_W-1:0]   r_idx, r_idx_next;
  logic                r_last, r_last_next;

  // Output register
  logic                o_valid, o_valid_next;
  logic                o_status, o_found, o_last;
  logic [HANDLE_W-1:0] o_item;
  logic [KIND_W-1:0]   o_kind;
  logic [EIDX_W-1:0]   o_idx;
  logic                o_load;
  logic                out_free;
  logic                accept;

  assign out_free  = !o_valid || res.ready;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  // Next state, store control and result fields
  always_comb begin
    state_next    = state;
    op_next       = op;
    val_next      = val;
    pos_next      = pos;
    cnt_next      = cnt;
    cursor_next   = cursor;
    scan_next     = scan;
    pend_next     = pend;
    cmp_idx_next  = cmp_idx;
    run_next      = run;
    r_status_next = r_status;
    r_found_next  = r_found;
    r_item_next   = r_item;
    r_kind_next   = r_kind;
    r_idx_next    = r_idx;
    r_last_next   = r_last;
    ra            = pos;
    we            = 1'b0;
    wa            = cnt[IDX_W-1:0];
    wd            = req.item_value;
    o_load        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_next       = req.req_type;
          val_next      = req.item_value;
          // default to a failure result; the arms below override
          r_status_next = 1'b1;
          r_found_next  = 1'b0;
          r_item_next   = '0;
          r_kind_next   = EV_NONE;
          r_idx_next    = '0;
          r_last_next   = 1'b1;
          state_next    = ST_RESULT;
          case (req.req_type)
            REQ_APPEND: begin
              if (int'(cnt) < CAPACITY) begin
                we            = 1'b1;
                cnt_next      = cnt + 1'b1;
                r_status_next = 1'b0;
                r_item_next   = req.item_value;
                r_kind_next   = EV_INSERT;
                r_idx_next    = EIDX_W'(cnt);
              end
            end
            REQ_DELETE: begin
              if (int'(req.entry_index) < int'(cnt)) begin
                pos_next   = IDX_W'(req.entry_index);
                state_next = ST_RD_ITEM;
              end
            end
            REQ_REMOVE, REQ_CONTAINS: begin
              scan_next  = '0;
              pend_next  = 1'b0;
              state_next = ST_SCAN;
            end
            REQ_TAKE: begin
              if (cnt != '0) begin
                state_next = ST_MOD;
              end
            end
            REQ_CLEAR: begin
              cursor_next   = '0;
              run_next      = '0;
              pos_next      = '0;
              r_status_next = 1'b0;
              if (cnt != '0) begin
                state_next = ST_RD_ITEM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Linear search: issue one read per cycle, compare the one before
      ST_SCAN: begin
        ra = scan[IDX_W-1:0];
        if (pend && rdata == val) begin
          pend_next = 1'b0;
          if (op == REQ_REMOVE) begin
            pos_next   = cmp_idx;
            state_next = ST_RD_ITEM;
          end else begin
            r_status_next = 1'b0;
            r_found_next  = 1'b1;
            state_next    = ST_RESULT;
          end
        end else if (scan < cnt) begin
          pend_next    = 1'b1;
          cmp_idx_next = scan[IDX_W-1:0];
          scan_next    = scan + 1'b1;
        end else begin
          pend_next     = 1'b0;
          r_status_next = (op == REQ_REMOVE);
          state_next    = ST_RESULT;
        end
      end

      // Reduce the cursor modulo the count by repeated subtraction
      ST_MOD: begin
        if (cursor >= cnt) begin
          cursor_next = cursor - cnt;
        end else begin
          pos_next   = cursor[IDX_W-1:0];
          state_next = ST_RD_ITEM;
        end
      end

      ST_RD_ITEM: begin
        ra         = pos;
        state_next = ST_RD_LAST;
      end

      // Capture the victim, read the last entry
      ST_RD_LAST: begin
        r_item_next = rdata;
        ra          = IDX_W'(cnt - 1'b1);
        state_next  = ST_WRITE;
      end

      // Move the last entry into the hole
      ST_WRITE: begin
        we            = 1'b1;
        wa            = pos;
        wd            = rdata;
        cnt_next      = cnt - 1'b1;
        r_status_next = 1'b0;
        r_kind_next   = EV_REMOVE;
        r_idx_next    = EIDX_W'(pos);
        r_last_next   = 1'b1;
        if (op == REQ_TAKE) begin
          cursor_next = CNT_W'(pos) + 1'b1;
        end
        if (op == REQ_CLEAR) begin
          r_last_next = (cnt == CNT_W'(1)) || (int'(run) == MAX_RUN - 1);
        end
        state_next = ST_RESULT;
      end

      // Hand the beat to the output register; loop for clear
      ST_RESULT: begin
        if (out_free) begin
          o_load = 1'b1;
          if (op == REQ_CLEAR && !r_last) begin
            run_next   = run + 1'b1;
            pos_next   = '0;
            state_next = ST_RD_ITEM;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    o_valid_next = o_valid;
    if (o_load) begin
      o_valid_next = 1'b1;
    end else if (res.ready) begin
      o_valid_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      cursor  <= '0;
      pend    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      cursor  <= cursor_next;
      pend    <= pend_next;
      o_valid <= o_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    val      <= val_next;
    pos      <= pos_next;
    scan     <= scan_next;
    cmp_idx  <= cmp_idx_next;
    run      <= run_next;
    r_status <= r_status_next;
    r_found  <= r_found_next;
    r_item   <= r_item_next;
    r_kind   <= r_kind_next;
    r_idx    <= r_idx_next;
    r_last   <= r_last_next;
    if (o_load) begin
      o_status <= r_status;
      o_found  <= r_found;
      o_item   <= r_item;
      o_kind   <= r_kind;
      o_idx    <= r_idx;
      o_last   <= r_last;
    end
  end

  assign res.valid       = o_valid;
  assign res.status      = o_status;
  assign res.found       = o_found;
  assign res.item_out    = o_item;
  assign res.event_kind  = o_kind;
  assign res.event_index = o_idx;
  assign res.last_of_run = o_last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cnt) <= CAPACITY)
    else $error("entry count above capacity");

  a_write_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> cnt == $past(cnt) - 1'b1)
    else $error("swap-remove did not drop the count by one");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && pend) |-> int'(cmp_idx) < int'(cnt))
    else $error("search compared an entry beyond the count");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_APPEND && int'(cnt) < CAPACITY)
      |=> cnt == $past(cnt) + 1'b1)
    else $error("append did not grow the count");

endmodule

/* test/testbench.sv */
// Testbench for unordered_handle_set: directed and random request traffic with a
// shadow copy of the set that predicts every result beat. Depends on ush_pkg,
// ush_req_if, ush_res_if and the unordered_handle_set RTL.
module testbench;
  import ush_pkg::*;

  // Request codes the block must reject
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  typedef struct packed {
    logic                status;
    logic                found;
    logic [HANDLE_W-1:0] item_out;
    logic [KIND_W-1:0]   event_kind;
    logic [EIDX_W-1:0]   event_index;
    logic                last_of_run;
  } res_beat_t;

  logic clk;
  logic rst;

  ush_req_if req_ch ();
  ush_res_if res_ch ();

  unordered_handle_set dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // Shadow copy of the set and the beats it says must come back
  logic [HANDLE_W-1:0] shadow_handles [CAPACITY];
  logic [CNT_W-1:0]    shadow_count;
  logic [CNT_W-1:0]    shadow_cursor;
  res_beat_t           awaited_beats [$];

  int send_gap_pct;
  int recv_stall_pct;
  int fail_count = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest awaited one
  always @(posedge clk) begin : check_results
    res_beat_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (awaited_beats.size() == 0) begin
        $error("unexpected result beat: item_out %h event_kind %0d",
               res_ch.item_out, res_ch.event_kind);
        fail_count++;
      end else begin
        want = awaited_beats.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, res_ch.found);
          fail_count++;
        end
        if (res_ch.item_out !== want.item_out) begin
          $error("item_out: expected %h, got %h", want.item_out, res_ch.item_out);
          fail_count++;
        end
        if (res_ch.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind, res_ch.event_kind);
          fail_count++;
        end
        if (res_ch.event_index !== want.event_index) begin
          $error("event_index: expected %0d, got %0d", want.event_index,
                 res_ch.event_index);
          fail_count++;
        end
        if (res_ch.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                 res_ch.last_of_run);
          fail_count++;
        end
      end
    end
  end

  function automatic void push_beat(input logic st, input logic fnd,
                                    input logic [HANDLE_W-1:0] item,
                                    input logic [KIND_W-1:0] kind,
                                    input logic [EIDX_W-1:0] idx, input logic last);
    res_beat_t b;
    b.status      = st;
    b.found       = fnd;
    b.item_out    = item;
    b.event_kind  = kind;
    b.event_index = idx;
    b.last_of_run = last;
    awaited_beats.push_back(b);
  endfunction

  // Move the last entry into the hole and hand back the deleted handle
  function automatic logic [HANDLE_W-1:0] shadow_swap_remove(input int pos);
    logic [HANDLE_W-1:0] gone;
    gone = shadow_handles[pos];
    shadow_count = shadow_count - 1'b1;
    shadow_handles[pos] = shadow_handles[shadow_count];
    return gone;
  endfunction

  // First position holding the handle, or the count when absent
  function automatic int shadow_find(input logic [HANDLE_W-1:0] v);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_handles[i] == v) return i;
    end
    return int'(shadow_count);
  endfunction

  // Apply one accepted request to the shadow set and queue its result beats
  function automatic void shadow_apply(input logic [REQ_W-1:0] kind,
                                       input logic [HANDLE_W-1:0] value,
                                       input logic [EIDX_W-1:0] index);
    int pos;
    int n;
    logic [HANDLE_W-1:0] item;
    case (kind)
      REQ_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          push_beat(1'b1, 1'b0, '0, EV_NONE, '0, 1'b1);
        end else begin
          shadow_handles[shadow_count] = value;
          shadow_count = shadow_count + 1'b1;
          push_beat(1'b0, 1'b0, value, EV_INSERT, EIDX_W'(shadow_count - 1'b1), 1'b1);
        end
      end
      REQ_DELETE: begin
        if (index >= shadow_count) begin
          push_beat(1'b1, 1'b0, '0, EV_NONE, '0, 1'b1);
        end else begin
          item = shadow_swap_remove(int'(index));
          push_beat(1'b0, 1'b0, item, EV_REMOVE, index, 1'b1);
        end
      end
      REQ_REMOVE: begin
        pos = shadow_find(value);
        if (pos >= shadow_count) begin
          push_beat(1'b1, 1'b0, '0, EV_NONE, '0, 1'b1);
        end else begin
          item = shadow_swap_remove(pos);
          push_beat(1'b0, 1'b0, item, EV_REMOVE, EIDX_W'(pos), 1'b1);
        end
      end
      REQ_CONTAINS: begin
        pos = shadow_find(value);
        push_beat(1'b0, pos < shadow_count, '0, EV_NONE, '0, 1'b1);
      end
      REQ_TAKE: begin
        if (shadow_count == 0) begin
          push_beat(1'b1, 1'b0, '0, EV_NONE, '0, 1'b1);
        end else begin
          pos = int'(shadow_cursor % shadow_count);
          item = shadow_swap_remove(pos);
          shadow_cursor = CNT_W'(pos + 1);
          push_beat(1'b0, 1'b0, item, EV_REMOVE, EIDX_W'(pos), 1'b1);
        end
      end
      REQ_CLEAR: begin
        shadow_cursor = '0;
        if (shadow_count == 0) begin
          push_beat(1'b0, 1'b0, '0, EV_NONE, '0, 1'b1);
        end else begin
          n = 0;
          while (shadow_count > 0 && n < MAX_RUN) begin
            item = shadow_swap_remove(0);
            push_beat(1'b0, 1'b0, item, EV_REMOVE, '0,
                      (shadow_count == 0) || (n == MAX_RUN - 1));
            n++;
          end
        end
      end
      default: begin
        push_beat(1'b1, 1'b0, '0, EV_NONE, '0, 1'b1);
      end
    endcase
  endfunction

  // Send one request beat after a random gap; valid stays high for the next call
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [HANDLE_W-1:0] value,
                              input logic [EIDX_W-1:0] index);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.item_value  <= value;
    req_ch.entry_index <= index;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    shadow_apply(kind, value, index);
  endtask

  // Handle drawn from the set with the given odds, else random or a corner value
  function automatic logic [HANDLE_W-1:0] pick_value(input int present_pct);
    int r;
    r = $urandom_range(99);
    if (shadow_count != 0 && r < present_pct)
      return shadow_handles[$urandom_range(shadow_count - 1)];
    if (r < 88) return $urandom;
    if (r < 95) return $urandom_range(7);
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [EIDX_W-1:0] pick_index();
    if (shadow_count != 0 && $urandom_range(3) != 0)
      return EIDX_W'($urandom_range(shadow_count - 1));
    return EIDX_W'($urandom_range(15));
  endfunction

  // Fill to capacity, the first seven with corner handles, then append once more
  task automatic test_fill_and_overflow();
    logic [HANDLE_W-1:0] corners [7];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    for (int i = 0; i < CAPACITY; i++) begin
      send_request(REQ_APPEND, (i < 7) ? corners[i] : $urandom, EIDX_W'(i));
    end
    send_request(REQ_APPEND, 32'h1234_5678, 4'hF);
  endtask

  // Search hits and misses, then two deletes at index 15, just past the top entry
  task automatic test_lookup_and_delete();
    send_request(REQ_CONTAINS, 32'hFFFF_FFFF, '0);
    send_request(REQ_REMOVE, 32'h0000_0000, '0);
    send_request(REQ_REMOVE, 32'hDEAD_0000, '0);
    send_request(REQ_DELETE, $urandom, 4'hF);
    send_request(REQ_DELETE, $urandom, 4'hF);
  endtask

  task automatic test_take_round_robin();
    send_request(REQ_TAKE, $urandom, EIDX_W'($urandom_range(15)));
    send_request(REQ_TAKE, $urandom, EIDX_W'($urandom_range(15)));
  endtask

  // Clear the set in one run, then hit the empty set and the reserved codes
  task automatic test_clear_and_rejects();
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_CLEAR, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_TAKE, '0, '0);
    send_request(REQ_RSVD_A, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_RSVD_B, '0, '0);
  endtask

  // Random mix, mostly well-formed, with bursts that fill the set to the top
  task automatic test_random_mix(input int n_items);
    int sent;
    int roll;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        while (shadow_count < CAPACITY) begin
          send_request(REQ_APPEND, pick_value(15), EIDX_W'($urandom_range(15)));
          sent++;
        end
        send_request(REQ_APPEND, pick_value(15), EIDX_W'($urandom_range(15)));
        sent++;
      end else begin
        if (roll < 34)
          send_request(REQ_APPEND, pick_value(15), EIDX_W'($urandom_range(15)));
        else if (roll < 46)
          send_request(REQ_DELETE, $urandom, pick_index());
        else if (roll < 58)
          send_request(REQ_REMOVE, pick_value(75), EIDX_W'($urandom_range(15)));
        else if (roll < 70)
          send_request(REQ_CONTAINS, pick_value(50), EIDX_W'($urandom_range(15)));
        else if (roll < 86)
          send_request(REQ_TAKE, $urandom, EIDX_W'($urandom_range(15)));
        else if (roll < 91)
          send_request(REQ_CLEAR, $urandom, EIDX_W'($urandom_range(15)));
        else if (roll < 94)
          send_request(REQ_W'($urandom_range(REQ_RSVD_B, REQ_RSVD_A)), $urandom,
                       EIDX_W'($urandom_range(15)));
        else
          send_request(REQ_W'($urandom_range(7)), $urandom,
                       EIDX_W'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  // Bound the run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    send_gap_pct        = 9;
    recv_stall_pct      = 49;
    shadow_count        = '0;
    shadow_cursor       = '0;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_APPEND;
    req_ch.item_value  <= '0;
    req_ch.entry_index <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_fill_and_overflow();
    test_lookup_and_delete();
    test_take_round_robin();
    test_clear_and_rejects();
    test_random_mix(50);

    send_gap_pct   = 49;
    recv_stall_pct = 9;
    test_random_mix(50);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_mix(50);

    // Drain outstanding beats, then watch for strays
    req_ch.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && awaited_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
